>>> rtl/pms_pkg.sv
// shared types and constants of the partition move selector
package pms_pkg;

    localparam int DEF_MAX_SHARDS  = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam int NODE_W   = 20;
    localparam int SHARD_W  = 4;
    localparam int PCT_W    = 7;
    localparam int CFG_W    = 5;
    localparam int GAIN_W   = 16;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [CFG_W-1:0] SHARD_COUNT_RESET = 5'd8;
    localparam logic [PCT_W-1:0] PCT_1ST_MAX       = 7'd49;
    localparam logic [PCT_W-1:0] PCT_2ND_MAX       = 7'd79;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOME,
        ST_EVAL,
        ST_DONE
    } pms_state_t;

    typedef enum logic [1:0] {
        CHOICE_1ST,
        CHOICE_2ND,
        CHOICE_3RD
    } pms_choice_t;

    typedef struct packed {
        logic               inc_en;
        logic [SHARD_W-1:0] nb_sel;
        logic               shift_en;
    } pms_cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic offer;
    } pms_rank_ctrl_t;

endpackage

>>> rtl/partition_move_selector.sv
// top level of the partition move selector
// Counts the neighbor partitions of one node into a chain of saturating cells, one
// cell per partition. Neighbor items are taken one per cycle while idle; s_tready is
// low during the scan and until the result is loaded. The item with tlast set starts
// the node-end scan: the chain rotates once to read the home count out of its head
// cell, then shifts in zeros, feeding one partition per cycle to the top-three
// ranking unit while the histogram clears. The result register is then loaded. It
// holds its item while the next node's neighbors are counted; only the end of the
// next scan waits for it to be taken. shard_count may be written only between nodes.
module partition_move_selector #(
    parameter int MAX_SHARDS  = pms_pkg::DEF_MAX_SHARDS,
    parameter int COUNT_WIDTH = pms_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pms_pkg::CFG_W-1:0]     cfg_wdata,   // shard_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // node_id[19:0], home_shard[23:20], neighbor_shard[27:24], rand_pct[34:28]
    input  logic [pms_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,     // has_neighbor
    input  logic                          s_tlast,     // last_neighbor
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_node_id[19:0], destination[23:20], move_gain[39:24]
    output logic [pms_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser      // move_valid
);
    import pms_pkg::*;

    localparam int PW = $clog2(MAX_SHARDS);
    localparam int NW = $clog2(MAX_SHARDS + 1);
    localparam int AW = (NW > CFG_W) ? NW : CFG_W;
    localparam int XW = (PW > SHARD_W) ? PW : SHARD_W;
    localparam int GW = (COUNT_WIDTH > GAIN_W) ? COUNT_WIDTH : GAIN_W;

    pms_state_t state_reg, state_next;

    logic [CFG_W-1:0]       shard_count_reg;
    logic [PW-1:0]          scan_reg, scan_next;
    logic                   scan_last;
    logic [NODE_W-1:0]      node_reg;
    logic [SHARD_W-1:0]     home_reg;
    logic [PCT_W-1:0]       pct_reg;
    logic                   home_ok_reg;
    logic [COUNT_WIDTH-1:0] home_cnt_reg;
    logic                   m_valid_reg;
    logic [M_DATA_W-1:0]    m_data_reg;
    logic                   m_user_reg;

    logic [AW-1:0]          active;
    logic                   s_accept;
    logic                   start;
    logic                   out_free;
    logic                   rotate;
    logic                   load_out;
    logic [NODE_W-1:0]      in_node;
    logic [SHARD_W-1:0]     in_home;
    logic [SHARD_W-1:0]     in_nb;
    logic [PCT_W-1:0]       in_pct;

    pms_cell_ctrl_t         cell_ctrl;
    pms_rank_ctrl_t         rank_ctrl;
    logic [COUNT_WIDTH-1:0] counts [MAX_SHARDS];
    logic [COUNT_WIDTH-1:0] head;
    logic                   cand_ok;
    pms_choice_t            choice;
    logic                   sel_valid;
    logic [COUNT_WIDTH-1:0] sel_gain;
    logic [PW-1:0]          sel_part;
    logic [GW-1:0]          gain_wide;
    logic [GAIN_W-1:0]      gain_out;
    logic [XW-1:0]          part_wide;

    assign in_node = s_tdata[NODE_W-1:0];
    assign in_home = s_tdata[NODE_W +: SHARD_W];
    assign in_nb   = s_tdata[NODE_W+SHARD_W +: SHARD_W];
    assign in_pct  = s_tdata[NODE_W+2*SHARD_W +: PCT_W];

    assign active = (AW'(shard_count_reg) < AW'(MAX_SHARDS)) ?
                    AW'(shard_count_reg) : AW'(MAX_SHARDS);

    assign s_accept  = s_tvalid && s_tready;
    assign start     = s_accept && s_tlast;
    assign out_free  = !m_valid_reg || m_tready;
    assign scan_last = (scan_reg == PW'(MAX_SHARDS - 1));
    assign head      = counts[0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_HOME;
                end
            end
            ST_HOME: begin
                if (scan_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready           = 1'b0;
        rotate             = 1'b0;
        load_out           = 1'b0;
        cell_ctrl.inc_en   = 1'b0;
        cell_ctrl.nb_sel   = in_nb;
        cell_ctrl.shift_en = 1'b0;
        rank_ctrl.clear    = 1'b0;
        rank_ctrl.offer    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready         = 1'b1;
                cell_ctrl.inc_en = s_accept && s_tuser && (AW'(in_nb) < active);
                rank_ctrl.clear  = start;
            end
            ST_HOME: begin
                rotate             = 1'b1;
                cell_ctrl.shift_en = 1'b1;
            end
            ST_EVAL: begin
                cell_ctrl.shift_en = 1'b1;
                rank_ctrl.offer    = cand_ok;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (state_reg == ST_HOME || state_reg == ST_EVAL) begin
            scan_next = scan_last ? '0 : scan_reg + PW'(1);
        end else begin
            scan_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            scan_reg        <= '0;
            shard_count_reg <= SHARD_COUNT_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            if (cfg_we) begin
                shard_count_reg <= cfg_wdata;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // node-end context and home count
    always_ff @(posedge aclk) begin
        if (start) begin
            node_reg     <= in_node;
            home_reg     <= in_home;
            pct_reg      <= in_pct;
            home_ok_reg  <= (AW'(in_home) < active);
            home_cnt_reg <= '0;
        end else if (state_reg == ST_HOME && home_ok_reg &&
                     AW'(scan_reg) == AW'(home_reg)) begin
            home_cnt_reg <= head;
        end
    end

    // cell chain: head is cell 0; rotate while reading home, then drain with zeros
    for (genvar i = 0; i < MAX_SHARDS; i++) begin : g_cell
        logic [COUNT_WIDTH-1:0] shift_in;
        if (i == MAX_SHARDS - 1) begin : g_tail
            assign shift_in = rotate ? counts[0] : '0;
        end else begin : g_body
            assign shift_in = counts[i+1];
        end
        pms_cell #(
            .CW    (COUNT_WIDTH),
            .INDEX (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .shift_in (shift_in),
            .count    (counts[i])
        );
    end

    assign cand_ok = (AW'(scan_reg) < active) && (AW'(scan_reg) != AW'(home_reg)) &&
                     (head > home_cnt_reg);

    always_comb begin
        if (pct_reg <= PCT_1ST_MAX) begin
            choice = CHOICE_1ST;
        end else if (pct_reg <= PCT_2ND_MAX) begin
            choice = CHOICE_2ND;
        end else begin
            choice = CHOICE_3RD;
        end
    end

    pms_rank #(
        .CW (COUNT_WIDTH),
        .PW (PW)
    ) u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rank_ctrl),
        .cand_gain (head - home_cnt_reg),
        .cand_part (scan_reg),
        .choice    (choice),
        .sel_valid (sel_valid),
        .sel_gain  (sel_gain),
        .sel_part  (sel_part)
    );

    assign gain_wide = GW'(sel_gain);
    assign gain_out  = (gain_wide > GW'({GAIN_W{1'b1}})) ? {GAIN_W{1'b1}} :
                       gain_wide[GAIN_W-1:0];
    assign part_wide = XW'(sel_part);

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_user_reg <= sel_valid;
            if (sel_valid) begin
                m_data_reg <= {gain_out, part_wide[SHARD_W-1:0], node_reg};
            end else begin
                m_data_reg <= {{GAIN_W{1'b0}}, {SHARD_W{1'b0}}, node_reg};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> rtl/pms_cell.sv
// one histogram cell: a saturating counter that also shifts along the chain
module pms_cell #(
    parameter int CW    = pms_pkg::DEF_COUNT_WIDTH,
    parameter int INDEX = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pms_pkg::pms_cell_ctrl_t ctrl,
    input  logic [CW-1:0]           shift_in,
    output logic [CW-1:0]           count
);
    import pms_pkg::*;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          hit;

    assign hit = ctrl.inc_en && (32'(ctrl.nb_sel) == INDEX) && (count_reg != {CW{1'b1}});

    always_comb begin
        if (ctrl.shift_en) begin
            count_next = shift_in;
        end else if (hit) begin
            count_next = count_reg + CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

>>> rtl/pms_rank.sv
// keeps the three best positive-gain moves and picks one by rank
module pms_rank #(
    parameter int CW = pms_pkg::DEF_COUNT_WIDTH,
    parameter int PW = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pms_pkg::pms_rank_ctrl_t ctrl,
    input  logic [CW-1:0]           cand_gain,
    input  logic [PW-1:0]           cand_part,
    input  pms_pkg::pms_choice_t    choice,
    output logic                    sel_valid,
    output logic [CW-1:0]           sel_gain,
    output logic [PW-1:0]           sel_part
);
    import pms_pkg::*;

    logic [CW-1:0] gain_reg [3];
    logic [CW-1:0] gain_next [3];
    logic [PW-1:0] part_reg [3];
    logic [PW-1:0] part_next [3];
    logic [1:0]    found_reg;
    logic [1:0]    found_next;
    logic          above0;
    logic          above1;
    logic          above2;
    logic [1:0]    pick;

    // scan runs upward, so an equal gain from a later partition ranks higher
    assign above0 = (found_reg == 2'd0) || (cand_gain >= gain_reg[0]);
    assign above1 = (found_reg <= 2'd1) || (cand_gain >= gain_reg[1]);
    assign above2 = (found_reg <= 2'd2) || (cand_gain >= gain_reg[2]);

    always_comb begin
        gain_next  = gain_reg;
        part_next  = part_reg;
        found_next = found_reg;
        if (ctrl.clear) begin
            found_next = 2'd0;
        end else if (ctrl.offer) begin
            if (found_reg != 2'd3) begin
                found_next = found_reg + 2'd1;
            end
            if (above0) begin
                gain_next[2] = gain_reg[1];
                part_next[2] = part_reg[1];
                gain_next[1] = gain_reg[0];
                part_next[1] = part_reg[0];
                gain_next[0] = cand_gain;
                part_next[0] = cand_part;
            end else if (above1) begin
                gain_next[2] = gain_reg[1];
                part_next[2] = part_reg[1];
                gain_next[1] = cand_gain;
                part_next[1] = cand_part;
            end else if (above2) begin
                gain_next[2] = cand_gain;
                part_next[2] = cand_part;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 2'd0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg <= gain_next;
        part_reg <= part_next;
    end

    // fewer moves than asked for: take the lowest-ranked one
    assign pick      = (2'(choice) < found_reg) ? 2'(choice) : (found_reg - 2'd1);
    assign sel_valid = (found_reg != 2'd0);
    assign sel_gain  = gain_reg[pick];
    assign sel_part  = part_reg[pick];

endmodule

>>> rtl/pms_checker.sv
// port-level checks of the partition move selector, bound to the top level
module pms_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pms_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import pms_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no move means zero destination and gain
    a_no_move_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[M_DATA_W-1:NODE_W] == '0)
        else $error("no-move result carries destination or gain");

    // a chosen move has a positive gain
    a_move_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[M_DATA_W-1:NODE_W+SHARD_W] != '0)
        else $error("move with zero gain");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind partition_move_selector pms_checker u_pms_checker (.*);

>>> tb/sv/testbench.sv
// self-checking testbench for the partition move selector
typedef struct packed {
    logic [pms_pkg::NODE_W-1:0]  node;
    logic                        valid;
    logic [pms_pkg::SHARD_W-1:0] dest;
    logic [pms_pkg::GAIN_W-1:0]  gain;
} move_t;

class move_tracker;
    bit [pms_pkg::DEF_COUNT_WIDTH-1:0] hist [pms_pkg::DEF_MAX_SHARDS];
    bit [pms_pkg::CFG_W-1:0]           shards;
    move_t                             pending_moves [$];
    int unsigned                       bad_moves;

    function new();
        shards    = pms_pkg::SHARD_COUNT_RESET;
        bad_moves = 0;
        foreach (hist[i]) hist[i] = '0;
    endfunction

    function int unsigned active_shards();
        return (32'(shards) < pms_pkg::DEF_MAX_SHARDS) ? 32'(shards)
                                                       : 32'(pms_pkg::DEF_MAX_SHARDS);
    endfunction

    // counts one neighbor item and, at the end of a node, queues the chosen move
    function void count_neighbor(input bit [pms_pkg::NODE_W-1:0] node,
                                 input bit [pms_pkg::SHARD_W-1:0] home,
                                 input bit has_nb,
                                 input bit [pms_pkg::SHARD_W-1:0] nb,
                                 input bit [pms_pkg::PCT_W-1:0] pct,
                                 input bit is_last);
        int unsigned         lim;
        int unsigned         home_cnt;
        int unsigned         gain;
        int unsigned         found;
        int unsigned         slot;
        int unsigned         pick;
        int unsigned         best_gain [3];
        int unsigned         best_part [3];
        pms_pkg::pms_choice_t choice;
        move_t               m;

        lim = active_shards();
        if (has_nb && 32'(nb) < lim && hist[nb] != '1) hist[nb] = hist[nb] + 1'b1;
        if (!is_last) return;

        home_cnt = (32'(home) < lim) ? 32'(hist[home]) : 0;
        found    = 0;
        for (int p = 0; p < lim; p++) begin
            if (p != int'(home) && 32'(hist[p]) > home_cnt) begin
                gain = 32'(hist[p]) - home_cnt;
                slot = (found < 3) ? found : 3;
                // move up past every entry it outranks, ties go to the higher partition
                while (slot > 0 && (gain > best_gain[slot-1] ||
                       (gain == best_gain[slot-1] && p > best_part[slot-1]))) begin
                    if (slot < 3) begin
                        best_gain[slot] = best_gain[slot-1];
                        best_part[slot] = best_part[slot-1];
                    end
                    slot--;
                end
                if (slot < 3) begin
                    best_gain[slot] = gain;
                    best_part[slot] = p;
                end
                if (found < 3) found++;
            end
        end

        if (pct <= pms_pkg::PCT_1ST_MAX)      choice = pms_pkg::CHOICE_1ST;
        else if (pct <= pms_pkg::PCT_2ND_MAX) choice = pms_pkg::CHOICE_2ND;
        else                                  choice = pms_pkg::CHOICE_3RD;

        m.node = node;
        if (found == 0) begin
            m.valid = 1'b0;
            m.dest  = '0;
            m.gain  = '0;
        end else begin
            pick    = (int'(choice) < found) ? int'(choice) : found - 1;
            m.valid = 1'b1;
            m.dest  = best_part[pick][pms_pkg::SHARD_W-1:0];
            m.gain  = (best_gain[pick] > 32'h0000_FFFF) ? '1
                                                        : best_gain[pick][pms_pkg::GAIN_W-1:0];
        end
        pending_moves = {pending_moves, m};
        foreach (hist[i]) hist[i] = '0;
    endfunction

    function void check_move(input logic [pms_pkg::M_DATA_W-1:0] data, input logic flag);
        move_t want;
        move_t got;

        got.node  = data[pms_pkg::NODE_W-1:0];
        got.valid = flag;
        got.dest  = data[pms_pkg::NODE_W +: pms_pkg::SHARD_W];
        got.gain  = data[pms_pkg::NODE_W + pms_pkg::SHARD_W +: pms_pkg::GAIN_W];
        if (pending_moves.size() == 0) begin
            if (bad_moves < 10)
                $display("unexpected move: node %h valid %0d dest %0d gain %0d",
                         got.node, got.valid, got.dest, got.gain);
            bad_moves++;
            return;
        end
        want = pending_moves.pop_front();
        if (got.node !== want.node || got.valid !== want.valid ||
            got.dest !== want.dest || got.gain !== want.gain) begin
            if (bad_moves < 10)
                $display("move mismatch: expected node %h valid %0d dest %0d gain %0d, %s",
                         want.node, want.valid, want.dest, want.gain,
                         $sformatf("got node %h valid %0d dest %0d gain %0d",
                                   got.node, got.valid, got.dest, got.gain));
            bad_moves++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 2 * pms_pkg::DEF_MAX_SHARDS + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 125;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [pms_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [pms_pkg::S_DATA_W-1:0] s_tdata   = '0;
    logic                         s_tuser   = 1'b0;
    logic                         s_tlast   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [pms_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tuser;

    move_tracker tracker = new();
    int unsigned burst_left  = 0;
    int unsigned stall_pct   = 0;
    int unsigned stall_tick  = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;

    partition_move_selector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver: stall rate is redrawn among 0, 25, 60 and 85 percent; zero rate gives clean stretches
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_move(m_tdata, m_tuser);
            stall_tick++;
            if (stall_tick % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_item(input bit [pms_pkg::NODE_W-1:0] node,
                             input bit [pms_pkg::SHARD_W-1:0] home,
                             input bit has_nb,
                             input bit [pms_pkg::SHARD_W-1:0] nb,
                             input bit [pms_pkg::PCT_W-1:0] pct,
                             input bit is_last);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_tdata  <= {5'b0, pct, nb, home, node};
        s_tuser  <= has_nb;
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.count_neighbor(node, home, has_nb, nb, pct, is_last);
        burst_left--;
    endtask

    task automatic wait_drained(input bit settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_moves.size() != 0);
        // the scan of a node has ended by the time its move came out
        if (settle) repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_shard_count(input bit [pms_pkg::CFG_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.shards = value;
    endtask

    // one node: neighbors clustered on a few partitions, with stray ids and empty items
    task automatic random_node();
        int unsigned                 lim;
        int unsigned                 len;
        bit [pms_pkg::SHARD_W-1:0]   hot [4];
        bit [pms_pkg::NODE_W-1:0]    node;
        bit [pms_pkg::NODE_W-1:0]    id;
        bit [pms_pkg::SHARD_W-1:0]   home;
        bit [pms_pkg::SHARD_W-1:0]   nb;
        bit                          has_nb;

        lim = tracker.active_shards();
        if (lim == 0) lim = 1;
        foreach (hot[i])
            hot[i] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, lim - 1));
        node = 20'($urandom);
        home = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : hot[$urandom_range(0, 3)];
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
        if (len == 0) begin
            push_item(node, home, 1'b0, 4'($urandom), 7'($urandom_range(0, 127)), 1'b1);
            items_sent++;
        end else begin
            for (int i = 0; i < len; i++) begin
                has_nb = ($urandom_range(0, 11) != 0);
                nb     = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : hot[$urandom_range(0, 3)];
                id     = ($urandom_range(0, 19) == 0) ? 20'($urandom) : node;
                push_item((i == len - 1) ? node : id, home, has_nb, nb,
                          7'($urandom_range(0, 127)), i == len - 1);
                items_sent++;
            end
        end
        if ($urandom_range(0, 24) == 0) wait_drained(1'b0);
    endtask

    initial begin
        bit [pms_pkg::CFG_W-1:0] phase_shards;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty neighbor list
        push_item(20'h00000, 4'd0, 1'b0, 4'd0, 7'd0, 1'b1);
        // home out of range, neighbor out of range ignored, third rank picked
        push_item(20'hFFFFF, 4'd15, 1'b1, 4'd2, 7'd0, 1'b0);
        push_item(20'hFFFFF, 4'd15, 1'b1, 4'd5, 7'd0, 1'b0);
        push_item(20'hFFFFF, 4'd15, 1'b1, 4'd5, 7'd0, 1'b0);
        push_item(20'hFFFFF, 4'd15, 1'b0, 4'd15, 7'd0, 1'b0);
        push_item(20'hFFFFF, 4'd15, 1'b1, 4'd12, 7'd0, 1'b0);
        push_item(20'hFFFFF, 4'd15, 1'b1, 4'd7, 7'd80, 1'b1);
        // home count beats every other partition
        push_item(20'h5A5A5, 4'd3, 1'b1, 4'd3, 7'd0, 1'b0);
        push_item(20'h5A5A5, 4'd3, 1'b1, 4'd3, 7'd0, 1'b0);
        push_item(20'h5A5A5, 4'd3, 1'b1, 4'd4, 7'd49, 1'b1);
        // second rank
        push_item(20'h12345, 4'd0, 1'b1, 4'd6, 7'd0, 1'b0);
        push_item(20'h12345, 4'd0, 1'b1, 4'd6, 7'd0, 1'b0);
        push_item(20'h12345, 4'd0, 1'b1, 4'd1, 7'd50, 1'b1);
        // upper edge of the second-rank band
        push_item(20'h6A000, 4'd0, 1'b1, 4'd1, 7'd0, 1'b0);
        push_item(20'h6A000, 4'd0, 1'b1, 4'd2, 7'd0, 1'b0);
        push_item(20'h6A000, 4'd0, 1'b1, 4'd2, 7'd0, 1'b0);
        push_item(20'h6A000, 4'd0, 1'b1, 4'd3, 7'd0, 1'b0);
        push_item(20'h6A000, 4'd0, 1'b1, 4'd3, 7'd0, 1'b0);
        push_item(20'h6A000, 4'd0, 1'b1, 4'd3, 7'd79, 1'b1);
        // fewer moves than the rank asks for, percentages past 99
        push_item(20'h00001, 4'd1, 1'b1, 4'd4, 7'd127, 1'b1);
        push_item(20'h00002, 4'd2, 1'b1, 4'd0, 7'd100, 1'b1);

        // no active partition, then one active partition with the home out of range
        wait_drained(1'b1);
        set_shard_count(5'd0);
        push_item(20'h00003, 4'd0, 1'b1, 4'd0, 7'd0, 1'b0);
        push_item(20'h00003, 4'd0, 1'b1, 4'd1, 7'd0, 1'b1);
        wait_drained(1'b1);
        set_shard_count(5'd1);
        push_item(20'h00004, 4'd1, 1'b1, 4'd0, 7'd0, 1'b0);
        push_item(20'h00004, 4'd1, 1'b1, 4'd0, 7'd0, 1'b1);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: phase_shards = 5'd16;
                1: phase_shards = 5'd2;
                2: phase_shards = 5'($urandom_range(3, 15));
                3: phase_shards = 5'd31;
                default: phase_shards = 5'($urandom_range(2, 16));
            endcase
            wait_drained(1'b1);
            set_shard_count(phase_shards);
            while (items_sent < (p + 1) * PHASE_ITEMS) random_node();
        end

        wait_drained(1'b1);
        if (tracker.bad_moves == 0 && tracker.pending_moves.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/pms_pkg.sv
rtl/pms_cell.sv
rtl/pms_rank.sv
rtl/partition_move_selector.sv
rtl/pms_checker.sv
tb/sv/testbench.sv
